[src/binary_lifting_lca_unit_macros.svh]
`ifndef BINARY_LIFTING_LCA_UNIT_MACROS_SVH
`define BINARY_LIFTING_LCA_UNIT_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define BLL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a condition in the cycle after its trigger.
`define BLL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/bll_pkg.sv]
package bll_pkg;

	// Node numbers as they appear on the ports
	localparam int NODE_W = 10;

	// Defaults for the top-level parameters
	localparam int NODES_DEF  = 1024;
	localparam int LEVELS_DEF = 10;

	// Level counter width, enough for up to sixteen levels
	localparam int LVL_W = 4;

	// Input command codes
	localparam logic CMD_ATTACH = 1'b0;
	localparam logic CMD_QUERY  = 1'b1;

	// Datapath operation codes
	localparam int OP_W = 4;
	localparam logic [OP_W-1:0] OP_NONE = 4'd0;
	localparam logic [OP_W-1:0] OP_LOAD = 4'd1;
	localparam logic [OP_W-1:0] OP_ATT  = 4'd2;
	localparam logic [OP_W-1:0] OP_AEND = 4'd3;
	localparam logic [OP_W-1:0] OP_QDEP = 4'd4;
	localparam logic [OP_W-1:0] OP_SWAP = 4'd5;
	localparam logic [OP_W-1:0] OP_LIFT = 4'd6;
	localparam logic [OP_W-1:0] OP_LCMP = 4'd7;
	localparam logic [OP_W-1:0] OP_JUMP = 4'd8;
	localparam logic [OP_W-1:0] OP_LAST = 4'd9;
	localparam logic [OP_W-1:0] OP_ANS  = 4'd10;
	localparam logic [OP_W-1:0] OP_PUSH = 4'd11;

	// Controller to datapath
	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [LVL_W-1:0] lvl;
		logic             use_data;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic a_zero;
		logic a_eq_b;
		logic out_free;
	} stat_t;

endpackage

[src/bll_ram.sv]
module bll_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write, and read with new data on an address collision
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= (we && (waddr == raddr)) ? wdata : mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[src/bll_ctrl.sv]
`include "binary_lifting_lca_unit_macros.svh"

module bll_ctrl #(
	parameter int LEVELS = bll_pkg::LEVELS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          command,
	output logic          in_stall,
	output bll_pkg::cmd_t cmd,
	input  bll_pkg::stat_t st
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_ATT  = 4'd1;
	localparam logic [3:0] S_AEND = 4'd2;
	localparam logic [3:0] S_QDEP = 4'd3;
	localparam logic [3:0] S_SWAP = 4'd4;
	localparam logic [3:0] S_LIFT = 4'd5;
	localparam logic [3:0] S_LCMP = 4'd6;
	localparam logic [3:0] S_JUMP = 4'd7;
	localparam logic [3:0] S_LAST = 4'd8;
	localparam logic [3:0] S_ANS  = 4'd9;
	localparam logic [3:0] S_DONE = 4'd10;

	localparam logic [bll_pkg::LVL_W-1:0] LVL_MAX = bll_pkg::LVL_W'(LEVELS - 1);

	logic [3:0]                state_q, state_d;
	logic [bll_pkg::LVL_W-1:0] lvl_q, lvl_d;

	assign in_stall = (state_q != S_IDLE);

	// Sequence the walk over the levels
	always_comb begin
		state_d      = state_q;
		lvl_d        = lvl_q;
		cmd.op       = bll_pkg::OP_NONE;
		cmd.lvl      = lvl_q;
		cmd.use_data = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = bll_pkg::OP_LOAD;
					lvl_d   = '0;
					state_d = (command == bll_pkg::CMD_QUERY) ? S_QDEP : S_ATT;
				end
			end
			S_ATT: begin
				if (st.a_zero) begin
					state_d = S_IDLE;
				end else begin
					cmd.op = bll_pkg::OP_ATT;
					if (lvl_q == LVL_MAX) begin
						state_d = S_AEND;
					end else begin
						lvl_d = lvl_q + 1'b1;
					end
				end
			end
			S_AEND: begin
				cmd.op  = bll_pkg::OP_AEND;
				state_d = S_IDLE;
			end
			S_QDEP: begin
				cmd.op  = bll_pkg::OP_QDEP;
				state_d = S_SWAP;
			end
			S_SWAP: begin
				cmd.op  = bll_pkg::OP_SWAP;
				lvl_d   = LVL_MAX;
				state_d = S_LIFT;
			end
			S_LIFT: begin
				cmd.op = bll_pkg::OP_LIFT;
				if (lvl_q == '0) begin
					state_d = S_LCMP;
				end else begin
					lvl_d = lvl_q - 1'b1;
				end
			end
			S_LCMP: begin
				cmd.op = bll_pkg::OP_LCMP;
				if (st.a_eq_b) begin
					state_d = S_DONE;
				end else begin
					lvl_d   = LVL_MAX;
					state_d = S_JUMP;
				end
			end
			S_JUMP: begin
				cmd.op       = bll_pkg::OP_JUMP;
				cmd.use_data = (lvl_q != LVL_MAX);
				if (lvl_q == '0) begin
					state_d = S_LAST;
				end else begin
					lvl_d = lvl_q - 1'b1;
				end
			end
			S_LAST: begin
				cmd.op  = bll_pkg::OP_LAST;
				state_d = S_ANS;
			end
			S_ANS: begin
				cmd.op  = bll_pkg::OP_ANS;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (st.out_free) begin
					cmd.op  = bll_pkg::OP_PUSH;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			lvl_q   <= '0;
		end else begin
			state_q <= state_d;
			lvl_q   <= lvl_d;
		end
	end

	`BLL_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, state_q != S_IDLE, "accept left idle")
	`BLL_ASSERT_NEXT(a_lift_end, state_q == S_LIFT && lvl_q == '0, state_q == S_LCMP, "lift overrun")
	`BLL_ASSERT_NOW(a_lvl_range, state_q != S_IDLE, lvl_q <= LVL_MAX, "level out of range")

endmodule

[src/bll_dpath.sv]
`include "binary_lifting_lca_unit_macros.svh"

module bll_dpath #(
	parameter int NODES  = bll_pkg::NODES_DEF,
	parameter int LEVELS = bll_pkg::LEVELS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bll_pkg::cmd_t               cmd,
	output bll_pkg::stat_t              st,
	input  logic [bll_pkg::NODE_W-1:0]  node_a,
	input  logic [bll_pkg::NODE_W-1:0]  node_b,
	input  logic                        out_stall,
	output logic                        out_valid,
	output logic [bll_pkg::NODE_W-1:0]  ancestor_node
);

	localparam int NIW       = $clog2(NODES);
	localparam int LW        = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int ANC_DEPTH = NODES * (2 ** LW);
	localparam logic [LEVELS-1:0] DEPTH_MAX = '1;

	localparam int NW = bll_pkg::NODE_W;

	logic [NW-1:0]     a_q, b_q, res_q, out_q;
	logic [LEVELS-1:0] diff_q;
	logic              take_q, out_valid_q;
	logic              za_q, zb_q, dza_q, dzb_q;

	logic [NW-1:0]     a_in, b_in;
	logic [NW-1:0]     anc_rd_a, anc_rd_b, ra_eff, rb_eff;
	logic [LEVELS-1:0] dep_rd_a, dep_rd_b, da_eff, db_eff, dep_wdata;
	logic [NW-1:0]     a_eff, b_eff, rd_node_a, rd_node_b, wval;
	logic [LW-1:0]     lvl;
	logic              anc_re_a, anc_re_b, anc_we, dep_re, dep_we, pair_ne;

	// Map node numbers beyond the table onto node 0
	assign a_in = (32'(node_a) < 32'(NODES)) ? node_a : '0;
	assign b_in = (32'(node_b) < 32'(NODES)) ? node_b : '0;

	assign lvl = cmd.lvl[LW-1:0];

	// Node 0 is never written: force its reads to zero
	assign ra_eff = za_q ? '0 : anc_rd_a;
	assign rb_eff = zb_q ? '0 : anc_rd_b;
	assign da_eff = dza_q ? '0 : dep_rd_a;
	assign db_eff = dzb_q ? '0 : dep_rd_b;

	assign pair_ne   = (ra_eff != rb_eff);
	assign dep_wdata = (da_eff == DEPTH_MAX) ? da_eff : da_eff + 1'b1;

	// Pick the nodes to advance and the table reads for this step
	always_comb begin
		a_eff     = a_q;
		b_eff     = b_q;
		rd_node_a = a_q;
		rd_node_b = b_q;
		wval      = b_q;
		anc_re_a  = 1'b0;
		anc_re_b  = 1'b0;
		anc_we    = 1'b0;
		dep_re    = 1'b0;
		dep_we    = 1'b0;
		unique case (cmd.op)
			bll_pkg::OP_ATT: begin
				wval      = (lvl == '0) ? b_q : ra_eff;
				anc_we    = 1'b1;
				rd_node_a = wval;
				anc_re_a  = 1'b1;
				dep_re    = (lvl == '0);
			end
			bll_pkg::OP_AEND: begin
				dep_we = 1'b1;
			end
			bll_pkg::OP_QDEP: begin
				dep_re = 1'b1;
			end
			bll_pkg::OP_LIFT: begin
				if (take_q) begin
					a_eff = ra_eff;
				end
				rd_node_a = a_eff;
				anc_re_a  = 1'b1;
			end
			bll_pkg::OP_LCMP: begin
				if (take_q) begin
					a_eff = ra_eff;
				end
			end
			bll_pkg::OP_JUMP: begin
				if (cmd.use_data && pair_ne) begin
					a_eff = ra_eff;
					b_eff = rb_eff;
				end
				rd_node_a = a_eff;
				rd_node_b = b_eff;
				anc_re_a  = 1'b1;
				anc_re_b  = 1'b1;
			end
			bll_pkg::OP_LAST: begin
				if (pair_ne) begin
					a_eff = ra_eff;
				end
				rd_node_a = a_eff;
				anc_re_a  = 1'b1;
			end
			bll_pkg::OP_NONE, bll_pkg::OP_LOAD, bll_pkg::OP_SWAP,
			bll_pkg::OP_ANS, bll_pkg::OP_PUSH: begin
			end
			default: begin
			end
		endcase
	end

	// Ancestor table, one copy per read port, written together
	bll_ram #(.WIDTH(NW), .DEPTH(ANC_DEPTH)) u_anc_a (
		.clk   (clk),
		.we    (anc_we),
		.waddr ({NIW'(a_q), lvl}),
		.wdata (wval),
		.re    (anc_re_a),
		.raddr ({NIW'(rd_node_a), lvl}),
		.rdata (anc_rd_a)
	);

	bll_ram #(.WIDTH(NW), .DEPTH(ANC_DEPTH)) u_anc_b (
		.clk   (clk),
		.we    (anc_we),
		.waddr ({NIW'(a_q), lvl}),
		.wdata (wval),
		.re    (anc_re_b),
		.raddr ({NIW'(rd_node_b), lvl}),
		.rdata (anc_rd_b)
	);

	// Depth table, same arrangement
	bll_ram #(.WIDTH(LEVELS), .DEPTH(NODES)) u_dep_a (
		.clk   (clk),
		.we    (dep_we),
		.waddr (NIW'(a_q)),
		.wdata (dep_wdata),
		.re    (dep_re),
		.raddr (NIW'(rd_node_a)),
		.rdata (dep_rd_a)
	);

	bll_ram #(.WIDTH(LEVELS), .DEPTH(NODES)) u_dep_b (
		.clk   (clk),
		.we    (dep_we),
		.waddr (NIW'(a_q)),
		.wdata (dep_wdata),
		.re    (dep_re),
		.raddr (NIW'(rd_node_b)),
		.rdata (dep_rd_b)
	);

	// Track reads of node 0
	always_ff @(posedge clk) begin
		if (anc_re_a) begin
			za_q <= (rd_node_a == '0);
		end
		if (anc_re_b) begin
			zb_q <= (rd_node_b == '0);
		end
		if (dep_re) begin
			dza_q <= (rd_node_a == '0);
			dzb_q <= (rd_node_b == '0);
		end
	end

	// Advance the working nodes
	always_ff @(posedge clk) begin
		case (cmd.op)
			bll_pkg::OP_LOAD: begin
				a_q <= a_in;
				b_q <= b_in;
			end
			bll_pkg::OP_SWAP: begin
				if (da_eff < db_eff) begin
					a_q    <= b_q;
					b_q    <= a_q;
					diff_q <= db_eff - da_eff;
				end else begin
					diff_q <= da_eff - db_eff;
				end
			end
			bll_pkg::OP_LIFT, bll_pkg::OP_LAST: begin
				a_q <= a_eff;
			end
			bll_pkg::OP_LCMP: begin
				a_q   <= a_eff;
				res_q <= a_eff;
			end
			bll_pkg::OP_JUMP: begin
				a_q <= a_eff;
				b_q <= b_eff;
			end
			bll_pkg::OP_ANS: begin
				res_q <= ra_eff;
			end
			bll_pkg::OP_PUSH: begin
				out_q <= res_q;
			end
			default: begin
			end
		endcase
	end

	// Lift flag and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			take_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == bll_pkg::OP_SWAP) begin
				take_q <= 1'b0;
			end else if (cmd.op == bll_pkg::OP_LIFT) begin
				take_q <= diff_q[lvl];
			end
			if (cmd.op == bll_pkg::OP_PUSH) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign st.a_zero   = (a_q == '0);
	assign st.a_eq_b   = (a_eff == b_q);
	assign st.out_free = !out_valid_q || !out_stall;

	assign out_valid     = out_valid_q;
	assign ancestor_node = out_q;

	`BLL_ASSERT_NOW(a_no_root_write, anc_we || dep_we, a_q != '0, "write to node 0")

endmodule

[src/binary_lifting_lca_unit.sv]
// Attach: one ancestor level written per cycle; an attach of node 0 writes nothing.
// Query: nodes on one path finish early and skip the jump walk; the next item is taken only
//   when the previous one is through. A result held by the output register delays the next
//   item's load.
// Rate is set by the ancestor table read port walking one level per cycle.
// Reset clears the controller and the output valid; the tables are not cleared,
//   and reads of node 0 are forced to zero, so no clearing pass runs.
module binary_lifting_lca_unit #(
	parameter int NODES  = bll_pkg::NODES_DEF,
	parameter int LEVELS = bll_pkg::LEVELS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        command,
	input  logic [bll_pkg::NODE_W-1:0]  node_a,
	input  logic [bll_pkg::NODE_W-1:0]  node_b,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [bll_pkg::NODE_W-1:0]  ancestor_node
);

	bll_pkg::cmd_t  cmd;
	bll_pkg::stat_t st;

	// Sequencer
	bll_ctrl #(.LEVELS(LEVELS)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.command  (command),
		.in_stall (in_stall),
		.cmd      (cmd),
		.st       (st)
	);

	// Tables and working registers
	bll_dpath #(.NODES(NODES), .LEVELS(LEVELS)) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.node_a        (node_a),
		.node_b        (node_b),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.ancestor_node (ancestor_node)
	);

endmodule
